// ----- sv/scba_pkg.sv -----
// Package for the size-class block allocator: types and constants.
`timescale 1ns / 1ps
package scba_pkg;

  localparam int unsigned RECORDS_DEF     = 256;
  localparam int unsigned POOLS_DEF       = 16;
  localparam int unsigned POOL_BYTES_DEF  = 1024 * 1024;
  localparam int unsigned NUM_CLASSES_DEF = 10;
  localparam int unsigned MIN_CLASS_BYTES = 8;
  localparam int unsigned TOTAL_W         = 25;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT   = 1'd1;
  localparam logic [4:0]           POOL_LIMIT_RESET = 5'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_NO_MEM  = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] request_size;
    logic [31:0] block_address;
  } req_t;

  typedef struct packed {
    logic [31:0]        granted_address;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] allocated_bytes;
    logic [TOTAL_W-1:0] free_bytes;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture request, compute class
    logic head_rd;    // read the free-list head record
    logic pop;        // commit free-list pop
    logic pool_step;  // examine one pool
    logic carve;      // commit new block
    logic scan_rd;    // read record at scan index
    logic scan_chk;   // compare record read last cycle
    logic push;       // commit free
    logic finish;     // emit result
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic too_big;
    logic head_valid;
    logic pool_found;
    logic pool_done;
    logic can_carve;
    logic match;
    logic scan_done;
  } sts_t;

endpackage

// ----- sv/scba_ctrl.sv -----
// Controller state machine of the size-class block allocator.
`timescale 1ns / 1ps
module scba_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  scba_pkg::sts_t  sts_i,
  output scba_pkg::cmd_t  cmd_o
);
  import scba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_HEAD, S_POP, S_POOL, S_CARVE, S_SCAN_RD, S_SCAN_CHK,
    S_PUSH, S_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) state_q <= S_DECODE;
        S_DECODE: begin
          if (sts_i.is_free) begin
            state_q <= S_SCAN_RD;
          end else if (sts_i.too_big) begin
            status_q <= ST_TOO_BIG;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_HEAD;
          end
        end
        S_HEAD: state_q <= sts_i.head_valid ? S_POP : S_POOL;
        S_POP: begin
          status_q <= ST_OK;
          state_q  <= S_DONE;
        end
        S_POOL: begin
          if (sts_i.pool_found || sts_i.pool_done) begin
            if (sts_i.can_carve) begin
              state_q <= S_CARVE;
            end else begin
              status_q <= ST_NO_MEM;
              state_q  <= S_DONE;
            end
          end
        end
        S_CARVE: begin
          status_q <= ST_OK;
          state_q  <= S_DONE;
        end
        S_SCAN_RD: begin
          if (sts_i.scan_done) begin
            status_q <= ST_UNKNOWN;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: state_q <= sts_i.match ? S_PUSH : S_SCAN_RD;
        S_PUSH: begin
          status_q <= ST_OK;
          state_q  <= S_DONE;
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && start_i;
    cmd_o.head_rd   = (state_q == S_DECODE);
    cmd_o.pop       = (state_q == S_POP);
    cmd_o.pool_step = (state_q == S_POOL);
    cmd_o.carve     = (state_q == S_CARVE);
    cmd_o.scan_rd   = (state_q == S_SCAN_RD);
    cmd_o.scan_chk  = (state_q == S_SCAN_CHK);
    cmd_o.push      = (state_q == S_PUSH);
    cmd_o.finish    = (state_q == S_DONE);
    cmd_o.status    = status_q;
  end

endmodule

// ----- sv/scba_dp.sv -----
// Datapath of the size-class block allocator: record memory, lists, pools, totals.
`timescale 1ns / 1ps
module scba_dp #(
  parameter int unsigned RECORDS     = scba_pkg::RECORDS_DEF,
  parameter int unsigned POOLS       = scba_pkg::POOLS_DEF,
  parameter int unsigned POOL_BYTES  = scba_pkg::POOL_BYTES_DEF,
  parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scba_pkg::req_t       req_i,
  input  logic [31:0]          base_address_i,
  input  logic [4:0]           pool_limit_i,
  input  scba_pkg::cmd_t       cmd_i,
  output scba_pkg::sts_t       sts_o,
  output logic                 done_o,
  output scba_pkg::rsp_t       rsp_o
);
  import scba_pkg::*;

  localparam int unsigned RIX_W  = $clog2(RECORDS);
  localparam int unsigned RCNT_W = $clog2(RECORDS + 1);
  localparam int unsigned PIX_W  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int unsigned PCNT_W = $clog2(POOLS + 1);
  localparam int unsigned PB_W   = $clog2(POOL_BYTES + 1);
  localparam int unsigned OFS_W  = $clog2(POOLS * POOL_BYTES);
  localparam int unsigned CIX_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned MAXCLS = MIN_CLASS_BYTES << (NUM_CLASSES - 1);

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [CIX_W-1:0] cls;
    logic             allocated;
    logic             link_valid;
    logic [RIX_W-1:0] link;
  } rec_t;

  // Record memory, one write port and one registered read port.
  rec_t             rec_mem [RECORDS];
  rec_t             rd_q;
  logic             rd_en;
  logic [RIX_W-1:0] rd_addr;
  logic             wr_en;
  logic [RIX_W-1:0] wr_addr;
  rec_t             wr_data;

  logic [RCNT_W-1:0]  rcount_q;
  logic [NUM_CLASSES-1:0] hvalid_q;
  logic [RIX_W-1:0]   head_q [NUM_CLASSES];
  logic [PB_W-1:0]    used_q [POOLS];
  logic [PCNT_W-1:0]  popen_q;
  logic [TOTAL_W-1:0] atot_q, ftot_q;

  logic               op_q;
  logic [CIX_W-1:0]   cls_q;
  logic               too_big_q;
  logic [31:0]        addr_q;
  logic [PCNT_W-1:0]  pidx_q;
  logic [RCNT_W-1:0]  sidx_q;
  logic [RIX_W-1:0]   hit_q;
  logic [31:0]        grant_q;
  logic               done_q;
  logic [1:0]         status_q;

  logic [CIX_W-1:0]   cls_c;
  logic               big_c;
  logic [PB_W-1:0]    bytes_w;
  logic [PCNT_W-1:0]  limit_w;
  logic               pool_fit;
  logic               pool_done;
  logic [PIX_W-1:0]   pix;
  logic               match_c;
  logic [31:0]        rd_addr_full;
  logic [TOTAL_W-1:0] bytes_t;

  // Class of the request: smallest power of two, at least MIN_CLASS_BYTES, not below the size.
  always_comb begin
    cls_c = '0;
    big_c = (32'(req_i.request_size) > 32'(MAXCLS));
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (32'(req_i.request_size) <= (32'(MIN_CLASS_BYTES) << c)) cls_c = CIX_W'(c);
    end
  end

  assign bytes_w  = PB_W'(MIN_CLASS_BYTES) << cls_q;
  assign bytes_t  = TOTAL_W'(bytes_w);
  assign limit_w  = (32'(pool_limit_i) < 32'(POOLS)) ? PCNT_W'(pool_limit_i) : PCNT_W'(POOLS);
  assign pix      = pidx_q[PIX_W-1:0];
  assign pool_done = (pidx_q >= popen_q);
  assign pool_fit = !pool_done &&
                    ((PB_W'(POOL_BYTES) - used_q[pix]) >= bytes_w);
  assign rd_addr_full = base_address_i + 32'(rd_q.offset);
  assign match_c  = rd_q.allocated && (rd_addr_full == addr_q);

  always_comb begin
    sts_o            = '0;
    sts_o.is_free    = op_q;
    sts_o.too_big    = too_big_q;
    sts_o.head_valid = hvalid_q[cls_q];
    sts_o.pool_found = pool_fit;
    sts_o.pool_done  = pool_done;
    sts_o.can_carve  = (rcount_q < RCNT_W'(RECORDS)) &&
                       (pool_fit || (popen_q < limit_w));
    sts_o.match      = match_c;
    sts_o.scan_done  = (sidx_q >= rcount_q);
  end

  // Memory port control.
  always_comb begin
    rd_en   = cmd_i.head_rd || cmd_i.scan_rd;
    rd_addr = cmd_i.head_rd ? head_q[cls_q] : sidx_q[RIX_W-1:0];
    wr_en   = cmd_i.pop || cmd_i.carve || cmd_i.push;
    wr_addr = cmd_i.carve ? rcount_q[RIX_W-1:0] : hit_q;
    wr_data = rd_q;
    if (cmd_i.pop) begin
      wr_data.allocated  = 1'b1;
      wr_data.link_valid = 1'b0;
    end else if (cmd_i.carve) begin
      wr_data.offset     = OFS_W'(32'(pix) * POOL_BYTES) +
                           OFS_W'(pool_fit ? used_q[pix] : '0);
      wr_data.cls        = cls_q;
      wr_data.allocated  = 1'b1;
      wr_data.link_valid = 1'b0;
      wr_data.link       = '0;
    end else begin
      wr_data.allocated  = 1'b0;
      wr_data.link_valid = hvalid_q[rd_q.cls];
      wr_data.link       = head_q[rd_q.cls];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= rec_mem[rd_addr];
    if (wr_en) rec_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= req_i.op;
      cls_q     <= cls_c;
      too_big_q <= big_c;
      addr_q    <= req_i.block_address;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcount_q <= '0;
      hvalid_q <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) head_q[i] <= '0;
      for (int i = 0; i < POOLS; i++) used_q[i] <= '0;
      popen_q  <= '0;
      atot_q   <= '0;
      ftot_q   <= '0;
      pidx_q   <= '0;
      sidx_q   <= '0;
      hit_q    <= '0;
      grant_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) begin
        pidx_q  <= '0;
        sidx_q  <= '0;
        grant_q <= '0;
      end
      if (cmd_i.head_rd) hit_q <= head_q[cls_q];
      if (cmd_i.pop) begin
        hvalid_q[cls_q] <= rd_q.link_valid;
        head_q[cls_q]   <= rd_q.link;
        atot_q          <= atot_q + bytes_t;
        ftot_q          <= ftot_q - bytes_t;
        grant_q         <= base_address_i + 32'(rd_q.offset);
      end
      if (cmd_i.pool_step && !pool_fit && !pool_done) pidx_q <= pidx_q + 1'b1;
      if (cmd_i.carve) begin
        rcount_q <= rcount_q + 1'b1;
        grant_q  <= base_address_i + 32'(wr_data.offset);
        atot_q   <= atot_q + bytes_t;
        if (pool_fit) begin
          used_q[pix] <= used_q[pix] + bytes_w;
          ftot_q      <= ftot_q - bytes_t;
        end else begin
          used_q[pix] <= bytes_w;
          popen_q     <= popen_q + 1'b1;
          ftot_q      <= ftot_q + TOTAL_W'(POOL_BYTES) - bytes_t;
        end
      end
      if (cmd_i.scan_rd) hit_q <= sidx_q[RIX_W-1:0];
      if (cmd_i.scan_chk) sidx_q <= sidx_q + 1'b1;
      if (cmd_i.push) begin
        hvalid_q[rd_q.cls]  <= 1'b1;
        head_q[rd_q.cls]    <= hit_q;
        atot_q <= atot_q - (TOTAL_W'(MIN_CLASS_BYTES) << rd_q.cls);
        ftot_q <= ftot_q + (TOTAL_W'(MIN_CLASS_BYTES) << rd_q.cls);
      end
      if (cmd_i.finish) status_q <= cmd_i.status;
    end
  end

  assign done_o = done_q;
  always_comb begin
    rsp_o.granted_address = (status_q == ST_OK) ? grant_q : '0;
    rsp_o.status          = status_q;
    rsp_o.allocated_bytes = atot_q;
    rsp_o.free_bytes      = ftot_q;
  end

endmodule

// ----- sv/size_class_block_allocator.sv -----
// Top level of the size-class block allocator.
// The path after the accepting edge: a size that is too large is refused after decode; an
// allocation reads the free-list head and pops it if valid, or else steps through the pools,
// passing over full ones, until a carve or an out-of-memory refusal; a free compares records
// one by one until one matches (all of them for an unknown address).
// One word is worked on at a time; busy is high until the result strobe, whose cycle may
// accept the next word. Reset clears lists, pools and totals at once; no stall is possible.
`timescale 1ns / 1ps
module size_class_block_allocator #(
  parameter int unsigned RECORDS     = scba_pkg::RECORDS_DEF,
  parameter int unsigned POOLS       = scba_pkg::POOLS_DEF,
  parameter int unsigned POOL_BYTES  = scba_pkg::POOL_BYTES_DEF,
  parameter int unsigned NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  scba_pkg::req_t                  req_i,
  output logic                            done_o,
  output scba_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import scba_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] base_q;
  logic [4:0]  limit_q;

  // Configuration is taken only while no word is being worked on, so a
  // request always sees one consistent base address and pool limit.
  assign cfg_ready_o = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= POOL_LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BASE_ADDRESS: base_q  <= cfg_data_i;
        CFG_POOL_LIMIT:   limit_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  scba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  scba_dp #(
    .RECORDS    (RECORDS),
    .POOLS      (POOLS),
    .POOL_BYTES (POOL_BYTES),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .base_address_i(base_q),
    .pool_limit_i  (limit_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

endmodule

// ----- sv/scba_checker.sv -----
// Port-level checker for the size-class block allocator, bound to the top level.
`timescale 1ns / 1ps
module scba_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input scba_pkg::rsp_t rsp_o
);
  import scba_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not raise busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without a word in work");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy still high with result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_OK) |-> (rsp_o.granted_address == '0))
    else $error("failed request gave an address");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);
